@@ hw/rtl/darr_pkg.sv @@
// ----------------------------------------------------------------------------
// darr_pkg
// Shared types and constants for the dual converter round-robin poller.
// ----------------------------------------------------------------------------
package darr_pkg;

  // Configuration register map, byte address is 4 * index
  localparam int unsigned CfgAddrW = 5;

  typedef enum logic [2:0] {
    REG_POLL_ENABLE = 3'd0,
    REG_DEV_ADDR_A  = 3'd1,
    REG_DEV_ADDR_B  = 3'd2,
    REG_WAIT_MS     = 3'd3,
    REG_LOW_BYTE    = 3'd4
  } darr_reg_e;

  localparam logic       PollEnableRst = 1'b1;
  localparam logic [6:0] DevAddrARst   = 7'd72;
  localparam logic [6:0] DevAddrBRst   = 7'd73;
  localparam logic [7:0] WaitMsRst     = 8'd8;
  localparam logic [7:0] LowByteRst    = 8'h83;

  typedef struct packed {
    logic       poll_enable;
    logic [6:0] device_address_a;
    logic [6:0] device_address_b;
    logic [7:0] convert_wait_ms;
    logic [7:0] config_low_byte;
  } darr_cfg_t;

  typedef enum logic [1:0] {
    MODE_POLL = 2'd0,
    MODE_DONE = 2'd1,
    MODE_HOST = 2'd2
  } darr_mode_e;

  typedef enum logic [1:0] {
    CMD_CONFIG  = 2'd0,
    CMD_POINTER = 2'd1,
    CMD_READ    = 2'd2
  } darr_cmd_e;

  typedef enum logic [2:0] {
    PH_CONFIG  = 3'd0,
    PH_POINTER = 3'd1,
    PH_WAIT    = 3'd2,
    PH_READ    = 3'd3,
    PH_STORE   = 3'd4
  } darr_phase_e;

  // Config high byte per input channel
  localparam logic [7:0] ChanTable [4] = '{8'hC7, 8'hD7, 8'hE7, 8'hF7};

endpackage

@@ hw/rtl/darr_if.sv @@
// ----------------------------------------------------------------------------
// darr_in_if / darr_out_if
// Valid/ready channels for poller events and poller results.
// ----------------------------------------------------------------------------
interface darr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] now_ms;
  logic [15:0] read_data;
  logic        xfer_error;
  logic [2:0]  read_offset;

  modport source (
    output valid, mode, now_ms, read_data, xfer_error, read_offset,
    input  ready
  );
  modport sink (
    input  valid, mode, now_ms, read_data, xfer_error, read_offset,
    output ready
  );
endinterface

interface darr_out_if;
  logic        valid;
  logic        ready;
  logic        cmd_valid;
  logic [1:0]  cmd_kind;
  logic [6:0]  target_address;
  logic [7:0]  channel_byte;
  logic [7:0]  low_config_byte;
  logic [15:0] host_data;
  logic        error_seen;

  modport source (
    output valid, cmd_valid, cmd_kind, target_address, channel_byte,
           low_config_byte, host_data, error_seen,
    input  ready
  );
  modport sink (
    input  valid, cmd_valid, cmd_kind, target_address, channel_byte,
           low_config_byte, host_data, error_seen,
    output ready
  );
endinterface

@@ hw/rtl/darr_apb_regs.sv @@
// ----------------------------------------------------------------------------
// darr_apb_regs
// APB configuration registers of the poller; always ready, no wait states.
// ----------------------------------------------------------------------------
module darr_apb_regs
  import darr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output darr_cfg_t           cfg_o
);

  darr_cfg_t cfg_q, cfg_d;
  logic      wr_en;
  darr_reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = darr_reg_e'(paddr[CfgAddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_POLL_ENABLE: cfg_d.poll_enable      = pwdata[0];
        REG_DEV_ADDR_A:  cfg_d.device_address_a = pwdata[6:0];
        REG_DEV_ADDR_B:  cfg_d.device_address_b = pwdata[6:0];
        REG_WAIT_MS:     cfg_d.convert_wait_ms  = pwdata[7:0];
        REG_LOW_BYTE:    cfg_d.config_low_byte  = pwdata[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_POLL_ENABLE: prdata = {31'd0, cfg_q.poll_enable};
      REG_DEV_ADDR_A:  prdata = {25'd0, cfg_q.device_address_a};
      REG_DEV_ADDR_B:  prdata = {25'd0, cfg_q.device_address_b};
      REG_WAIT_MS:     prdata = {24'd0, cfg_q.convert_wait_ms};
      REG_LOW_BYTE:    prdata = {24'd0, cfg_q.config_low_byte};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_enable      <= PollEnableRst;
      cfg_q.device_address_a <= DevAddrARst;
      cfg_q.device_address_b <= DevAddrBRst;
      cfg_q.convert_wait_ms  <= WaitMsRst;
      cfg_q.config_low_byte  <= LowByteRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/dual_adc_round_robin_poller.sv @@
// ----------------------------------------------------------------------------
// dual_adc_round_robin_poller
// Round-robin sequencer for two four-input converters with a result cache.
// An accepted input beat is registered and shows as its result beat in the next cycle.
// Throughput: one item per cycle while results are taken; the output register
// frees as its beat is taken, so input ready follows output ready combinationally.
// Reset: config registers take their defaults, sequencer starts in the
// config write phase, cache and error flag clear, output register empties.
// ----------------------------------------------------------------------------
module dual_adc_round_robin_poller
  import darr_pkg::*;
#(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  darr_in_if.sink             req_i,
  darr_out_if.source          rsp_o
);

  darr_cfg_t cfg;

  darr_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer state
  darr_phase_e phase_q, phase_d;
  logic        busy_q, busy_d;
  logic        dev_sel_q, dev_sel_d;
  logic [1:0]  chan_q, chan_d;
  logic [31:0] start_q, start_d;
  logic [15:0] rbuf_q, rbuf_d;
  logic        err_q, err_d;
  logic [15:0] cache_q [8];
  logic        cache_we;
  logic [2:0]  cache_waddr;

  // Output register
  logic        out_vld_q;
  logic        cmd_vld_d, cmd_vld_q;
  darr_cmd_e   kind_d, kind_q;
  logic [6:0]  addr_d, addr_q;
  logic [7:0]  chb_d, chb_q;
  logic [7:0]  lowb_d, lowb_q;
  logic [15:0] hdata_d, hdata_q;
  logic        err_out_q;

  logic        fire;
  logic [6:0]  cur_addr;
  logic [31:0] elapsed;
  logic [2:0]  chan_inc;

  assign req_i.ready = ~out_vld_q | rsp_o.ready;
  assign fire        = req_i.valid & req_i.ready;

  assign cur_addr = dev_sel_q ? cfg.device_address_b : cfg.device_address_a;
  assign elapsed  = req_i.now_ms - start_q;
  assign chan_inc = {1'b0, chan_q} + 3'd1;

  always_comb begin
    phase_d     = phase_q;
    busy_d      = busy_q;
    dev_sel_d   = dev_sel_q;
    chan_d      = chan_q;
    start_d     = start_q;
    rbuf_d      = rbuf_q;
    err_d       = err_q;
    cache_we    = 1'b0;
    cache_waddr = {1'b0, chan_q};
    cmd_vld_d   = 1'b0;
    kind_d      = CMD_CONFIG;
    addr_d      = 7'd0;
    chb_d       = 8'd0;
    lowb_d      = 8'd0;
    hdata_d     = 16'd0;

    case (darr_mode_e'(req_i.mode))
      MODE_POLL: begin
        if (cfg.poll_enable && !busy_q) begin
          case (phase_q)
            PH_POINTER: begin
              busy_d    = 1'b1;
              cmd_vld_d = 1'b1;
              kind_d    = CMD_POINTER;
              addr_d    = cur_addr;
              dev_sel_d = ~dev_sel_q;
              if (dev_sel_q) begin
                start_d = req_i.now_ms;
                phase_d = PH_WAIT;
              end
            end
            PH_WAIT: begin
              if (elapsed > {24'd0, cfg.convert_wait_ms}) begin
                phase_d = PH_READ;
              end
            end
            PH_READ: begin
              busy_d    = 1'b1;
              cmd_vld_d = 1'b1;
              kind_d    = CMD_READ;
              addr_d    = cur_addr;
              phase_d   = PH_STORE;
            end
            PH_STORE: begin
              cache_we    = 1'b1;
              cache_waddr = {dev_sel_q, chan_q};
              dev_sel_d   = ~dev_sel_q;
              if (!dev_sel_q) begin
                phase_d = PH_READ;
              end else begin
                // advance to the next channel, wrapping at CHANNELS
                chan_d  = (chan_inc >= 3'(CHANNELS)) ? 2'd0 : chan_inc[1:0];
                phase_d = PH_CONFIG;
              end
            end
            default: begin
              // config write phase; unreachable codes land here as well
              busy_d    = 1'b1;
              cmd_vld_d = 1'b1;
              kind_d    = CMD_CONFIG;
              addr_d    = cur_addr;
              chb_d     = ChanTable[chan_q];
              lowb_d    = cfg.config_low_byte;
              dev_sel_d = ~dev_sel_q;
              phase_d   = dev_sel_q ? PH_POINTER : PH_CONFIG;
            end
          endcase
        end
      end
      MODE_DONE: begin
        busy_d = 1'b0;
        rbuf_d = req_i.read_data;
        err_d  = err_q | req_i.xfer_error;
      end
      MODE_HOST: begin
        hdata_d = cache_q[req_i.read_offset];
      end
      default: begin
        // unused mode: report the error flag only
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_CONFIG;
      busy_q    <= 1'b0;
      dev_sel_q <= 1'b0;
      chan_q    <= 2'd0;
      start_q   <= 32'd0;
      rbuf_q    <= 16'd0;
      err_q     <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        cache_q[i] <= 16'd0;
      end
    end else if (fire) begin
      phase_q   <= phase_d;
      busy_q    <= busy_d;
      dev_sel_q <= dev_sel_d;
      chan_q    <= chan_d;
      start_q   <= start_d;
      rbuf_q    <= rbuf_d;
      err_q     <= err_d;
      if (cache_we) begin
        cache_q[cache_waddr] <= rbuf_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result payload: load on every accepted beat, hold otherwise
  always_ff @(posedge clk_i) begin
    if (fire) begin
      cmd_vld_q <= cmd_vld_d;
      kind_q    <= kind_d;
      addr_q    <= addr_d;
      chb_q     <= chb_d;
      lowb_q    <= lowb_d;
      hdata_q   <= hdata_d;
      err_out_q <= err_d;
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.cmd_valid       = cmd_vld_q;
  assign rsp_o.cmd_kind        = kind_q;
  assign rsp_o.target_address  = addr_q;
  assign rsp_o.channel_byte    = chb_q;
  assign rsp_o.low_config_byte = lowb_q;
  assign rsp_o.host_data       = hdata_q;
  assign rsp_o.error_seen      = err_out_q;

endmodule

@@ test/dual_adc_round_robin_poller_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_adc_round_robin_poller_tb
// Drives poll, transfer-done, host-read and unused-mode beats into the poller
// and checks every result beat against a cycle-free model of the sequencer.
// The model covers the config, pointer, wait, read and store phases, the
// result cache and the sticky error flag. The run moves through several
// register settings, the extremes among them, and stalls both channels at
// random.
// ----------------------------------------------------------------------------
package darr_tb_pkg;
  import darr_pkg::*;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic [15:0] read_data;
    logic        xfer_error;
    logic [2:0]  read_offset;
  } poll_event_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [1:0]  cmd_kind;
    logic [6:0]  target_address;
    logic [7:0]  channel_byte;
    logic [7:0]  low_config_byte;
    logic [15:0] host_data;
    logic        error_seen;
  } poll_result_t;

  class poll_scoreboard;
    logic         poll_en;
    logic [6:0]   addr_a;
    logic [6:0]   addr_b;
    logic [7:0]   wait_ms;
    logic [7:0]   low_byte;
    darr_phase_e  phase;
    logic         busy;
    logic         dev_sel;
    logic [1:0]   chan_idx;
    logic [31:0]  start_ms;
    logic [15:0]  read_buf;
    logic [15:0]  cache [8];
    logic         err_flag;
    poll_result_t pending_results [$];
    int           failures;

    function new();
      poll_en  = PollEnableRst;
      addr_a   = DevAddrARst;
      addr_b   = DevAddrBRst;
      wait_ms  = WaitMsRst;
      low_byte = LowByteRst;
      phase    = PH_CONFIG;
      busy     = 1'b0;
      dev_sel  = 1'b0;
      chan_idx = 2'd0;
      start_ms = '0;
      read_buf = '0;
      foreach (cache[i]) cache[i] = '0;
      err_flag = 1'b0;
      failures = 0;
    endfunction

    function void write_reg(darr_reg_e idx, logic [31:0] val);
      case (idx)
        REG_POLL_ENABLE: poll_en  = val[0];
        REG_DEV_ADDR_A:  addr_a   = val[6:0];
        REG_DEV_ADDR_B:  addr_b   = val[6:0];
        REG_WAIT_MS:     wait_ms  = val[7:0];
        REG_LOW_BYTE:    low_byte = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [6:0] cur_addr();
      return dev_sel ? addr_b : addr_a;
    endfunction

    function poll_result_t predict_response(poll_event_t ev);
      poll_result_t r;
      logic [1:0]   ch;
      r  = '0;
      ch = chan_idx;
      case (ev.mode)
        MODE_POLL: begin
          if (poll_en && !busy) begin
            case (phase)
              PH_POINTER: begin
                busy             = 1'b1;
                r.cmd_valid      = 1'b1;
                r.cmd_kind       = CMD_POINTER;
                r.target_address = cur_addr();
                if (!dev_sel) begin
                  dev_sel = 1'b1;
                end else begin
                  dev_sel  = 1'b0;
                  start_ms = ev.now_ms;
                  phase    = PH_WAIT;
                end
              end
              PH_WAIT: begin
                // wrapping elapsed time must strictly exceed the wait
                if (32'(ev.now_ms - start_ms) > {24'd0, wait_ms}) phase = PH_READ;
              end
              PH_READ: begin
                busy             = 1'b1;
                r.cmd_valid      = 1'b1;
                r.cmd_kind       = CMD_READ;
                r.target_address = cur_addr();
                phase            = PH_STORE;
              end
              PH_STORE: begin
                if (!dev_sel) begin
                  cache[{1'b0, ch}] = read_buf;
                  dev_sel           = 1'b1;
                  phase             = PH_READ;
                end else begin
                  cache[{1'b1, ch}] = read_buf;
                  dev_sel           = 1'b0;
                  chan_idx          = ch + 2'd1;
                  phase             = PH_CONFIG;
                end
              end
              default: begin
                busy              = 1'b1;
                r.cmd_valid       = 1'b1;
                r.cmd_kind        = CMD_CONFIG;
                r.target_address  = cur_addr();
                r.channel_byte    = ChanTable[ch];
                r.low_config_byte = low_byte;
                if (!dev_sel) begin
                  dev_sel = 1'b1;
                  phase   = PH_CONFIG;
                end else begin
                  dev_sel = 1'b0;
                  phase   = PH_POINTER;
                end
              end
            endcase
          end
        end
        MODE_DONE: begin
          busy     = 1'b0;
          read_buf = ev.read_data;
          if (ev.xfer_error) err_flag = 1'b1;
        end
        MODE_HOST: r.host_data = cache[ev.read_offset];
        default: ;
      endcase
      r.error_seen = err_flag;
      return r;
    endfunction

    function void note_input(poll_event_t ev);
      pending_results.push_back(predict_response(ev));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      failures++;
      if (failures <= 10)
        $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endfunction

    function void check_result(poll_result_t got);
      poll_result_t want;
      if (pending_results.size() == 0) begin
        flag("result beat with nothing pending", 32'(0), 32'(got));
        return;
      end
      want = pending_results.pop_front();
      if (got.cmd_valid !== want.cmd_valid)
        flag("cmd_valid", 32'(want.cmd_valid), 32'(got.cmd_valid));
      if (got.cmd_kind !== want.cmd_kind)
        flag("cmd_kind", 32'(want.cmd_kind), 32'(got.cmd_kind));
      if (got.target_address !== want.target_address)
        flag("target_address", 32'(want.target_address), 32'(got.target_address));
      if (got.channel_byte !== want.channel_byte)
        flag("channel_byte", 32'(want.channel_byte), 32'(got.channel_byte));
      if (got.low_config_byte !== want.low_config_byte)
        flag("low_config_byte", 32'(want.low_config_byte), 32'(got.low_config_byte));
      if (got.host_data !== want.host_data)
        flag("host_data", 32'(want.host_data), 32'(got.host_data));
      if (got.error_seen !== want.error_seen)
        flag("error_seen", 32'(want.error_seen), 32'(got.error_seen));
    endfunction
  endclass

endpackage

module dual_adc_round_robin_poller_tb;
  import darr_pkg::*;
  import darr_tb_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  darr_in_if  req_if ();
  darr_out_if rsp_if ();

  poll_scoreboard sb;
  bit             idle_on = 1'b0;
  int unsigned    sink_hold = 0;
  logic [31:0]    ms_clock;

  dual_adc_round_robin_poller DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .rsp_o   (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side: stall at random in bursts
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold    <= sink_hold - 1;
      rsp_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      sink_hold    <= $urandom_range(0, 9);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      sb.check_result({rsp_if.cmd_valid, rsp_if.cmd_kind, rsp_if.target_address,
                       rsp_if.channel_byte, rsp_if.low_config_byte, rsp_if.host_data,
                       rsp_if.error_seen});
  end

  function automatic poll_event_t mk_event(logic [1:0] mode, logic [31:0] now,
                                           logic [15:0] data, logic err,
                                           logic [2:0] off);
    poll_event_t ev;
    ev.mode        = mode;
    ev.now_ms      = now;
    ev.read_data   = data;
    ev.xfer_error  = err;
    ev.read_offset = off;
    return ev;
  endfunction

  // Shaped beats follow the sequencer: answer each issued transfer with a
  // done beat and advance the millisecond count on polls. Others are noise.
  function automatic poll_event_t make_event(bit shaped);
    poll_event_t ev;
    int unsigned pick;
    ev = mk_event(2'($urandom_range(0, 3)), $urandom, 16'($urandom),
                  1'($urandom_range(0, 1)), 3'($urandom));
    if (!shaped) return ev;
    pick          = $urandom_range(0, 99);
    ev.xfer_error = ($urandom_range(0, 24) == 0);
    if (pick >= 88)   ev.mode = MODE_HOST;
    else if (sb.busy) ev.mode = (pick < 80) ? MODE_DONE : MODE_POLL;
    else              ev.mode = MODE_POLL;
    if (ev.mode == MODE_POLL) begin
      ms_clock  += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 3);
      ev.now_ms  = ms_clock;
    end
    return ev;
  endfunction

  task automatic send_event(poll_event_t ev);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= ev.mode;
    req_if.now_ms      <= ev.now_ms;
    req_if.read_data   <= ev.read_data;
    req_if.xfer_error  <= ev.xfer_error;
    req_if.read_offset <= ev.read_offset;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_input(ev);
  endtask

  task automatic write_reg(darr_reg_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic        en;
    logic [6:0]  a_addr;
    logic [6:0]  b_addr;
    logic [7:0]  wait_val;
    logic [7:0]  low_val;
    int unsigned n_items;

    sb = new();
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    req_if.valid       <= 1'b0;
    req_if.mode        <= MODE_POLL;
    req_if.now_ms      <= '0;
    req_if.read_data   <= '0;
    req_if.xfer_error  <= 1'b0;
    req_if.read_offset <= '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty cache, unused mode, one full pass with a wrapping wait
    send_event(mk_event(MODE_HOST, '0, '0, 1'b0, 3'd0));
    send_event(mk_event(MODE_HOST, '1, '1, 1'b1, 3'd7));
    send_event(mk_event(2'd3, '1, '1, 1'b1, 3'd7));
    send_event(mk_event(MODE_POLL, '0, '0, 1'b0, 3'd0));
    send_event(mk_event(MODE_POLL, '0, '0, 1'b0, 3'd0));  // busy, drop
    send_event(mk_event(MODE_DONE, '0, 16'h0000, 1'b0, 3'd0));
    send_event(mk_event(MODE_POLL, 32'd1, '0, 1'b0, 3'd0));
    send_event(mk_event(MODE_DONE, '0, 16'h1234, 1'b0, 3'd0));
    send_event(mk_event(MODE_POLL, 32'd2, '0, 1'b0, 3'd0));
    send_event(mk_event(MODE_DONE, '0, 16'h0000, 1'b0, 3'd0));
    send_event(mk_event(MODE_POLL, 32'hFFFF_FFFC, '0, 1'b0, 3'd0));
    send_event(mk_event(MODE_DONE, '0, 16'h0000, 1'b0, 3'd0));
    send_event(mk_event(MODE_POLL, 32'd4, '0, 1'b0, 3'd0));  // elapsed equals wait, hold
    send_event(mk_event(MODE_POLL, 32'd5, '0, 1'b0, 3'd0));
    send_event(mk_event(MODE_POLL, 32'd6, '0, 1'b0, 3'd0));
    send_event(mk_event(MODE_DONE, '0, 16'hFFFF, 1'b0, 3'd0));
    send_event(mk_event(MODE_POLL, 32'd7, '0, 1'b0, 3'd0));
    send_event(mk_event(MODE_POLL, 32'd8, '0, 1'b0, 3'd0));
    send_event(mk_event(MODE_DONE, '0, 16'hA55A, 1'b1, 3'd0));
    send_event(mk_event(MODE_POLL, 32'd9, '0, 1'b0, 3'd0));
    send_event(mk_event(MODE_HOST, '0, '0, 1'b0, 3'd0));
    send_event(mk_event(MODE_HOST, '0, '0, 1'b0, 3'd4));

    for (int p = 0; p < 7; p++) begin
      req_if.valid <= 1'b0;
      wait_drained();
      case (p)
        0: begin
          en = 1'b1; a_addr = 7'd0; b_addr = 7'd127; wait_val = 8'd0; low_val = 8'd0;
        end
        1: begin
          en = 1'b1; a_addr = 7'd127; b_addr = 7'd0; wait_val = 8'd255; low_val = 8'd255;
        end
        default: begin
          en       = (p != 2);
          a_addr   = 7'($urandom);
          b_addr   = 7'($urandom);
          wait_val = 8'($urandom_range(0, 20));
          low_val  = 8'($urandom);
        end
      endcase
      write_reg(REG_POLL_ENABLE, {31'd0, en});
      write_reg(REG_DEV_ADDR_A, {25'd0, a_addr});
      write_reg(REG_DEV_ADDR_B, {25'd0, b_addr});
      write_reg(REG_WAIT_MS, {24'd0, wait_val});
      write_reg(REG_LOW_BYTE, {24'd0, low_val});
      ms_clock = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FF00 : $urandom;
      n_items  = (p == 2) ? 60 : 290;
      for (int i = 0; i < n_items; i++) begin
        idle_on = (p != 6) && ((i / 50) % 4 != 3);
        send_event(make_event($urandom_range(0, 99) < 80));
      end
    end

    req_if.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.failures == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
